// File: hdl/sdaf_pkg.sv
// ============================================================================
// sdaf_pkg
// Shared constants, types and the helper function of the signed decimal
// ASCII formatter.
// ============================================================================
package sdaf_pkg;

    // exponent of the highest power of ten examined (0 to 18)
    localparam int unsigned HIGHEST_POWER = 10;

    // one digit position per power of ten, units included
    localparam int unsigned NUM_DIGITS = HIGHEST_POWER + 1;

    // input word and magnitude widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned MAG_W   = VALUE_W + 1;

    // digit count and digit index widths
    localparam int unsigned CNT_W     = $clog2(NUM_DIGITS + 1);
    localparam int unsigned DIG_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam int unsigned RADIX     = 10;

    // power of ten at 64 bits, used at elaboration only
    function automatic logic [63:0] pow10(input int unsigned e);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned k = 0; k < e; k++) begin
            p = p * 64'(RADIX);
        end
        return p;
    endfunction

    // largest magnitude the digit positions can show
    localparam logic [63:0] MAG_LIMIT = pow10(NUM_DIGITS) - 64'd1;

    typedef logic [3:0] t_digit;
    typedef t_digit [NUM_DIGITS-1:0] t_digits;

    // work word that travels down the pipeline
    typedef struct packed {
        logic             neg;
        logic             started;
        logic [MAG_W-1:0] mag;
        logic [CNT_W-1:0] cnt;
        t_digits          digs;
    } t_work;

endpackage

// File: hdl/sdaf_if.sv
// ============================================================================
// sdaf_if
// Valid/ready channels of the formatter: the number input and the
// character output.
// ============================================================================

// number input channel
interface sdaf_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdaf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// character output channel
interface sdaf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: hdl/sdaf_front.sv
// ============================================================================
// sdaf_front
// Entry stage: takes the sign, forms the magnitude at 33 bits and clamps it
// to the largest value the digit positions can show.
// ============================================================================
module sdaf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] i_value,
    output logic                                o_ready,
    output logic                                o_valid,
    output sdaf_pkg::t_work                     o_work,
    input  logic                                i_ready
);
    import sdaf_pkg::*;

    logic             r_v;
    t_work            r_work;
    t_work            n_work;
    logic [MAG_W-1:0] w_mag;

    // stage can load when empty or when its word moves on
    assign o_ready = !r_v || i_ready;

    // sign and magnitude with clamp
    always_comb begin
        n_work = '0;
        n_work.neg = i_value[VALUE_W-1];
        if (i_value[VALUE_W-1]) begin
            w_mag = MAG_W'(0) - {i_value[VALUE_W-1], i_value};
        end else begin
            w_mag = {1'b0, i_value};
        end
        if (64'(w_mag) > MAG_LIMIT) begin
            n_work.mag = MAG_LIMIT[MAG_W-1:0];
        end else begin
            n_work.mag = w_mag;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_v;
    assign o_work  = r_work;

endmodule

// File: hdl/sdaf_digit_pipe.sv
// ============================================================================
// sdaf_digit_pipe
// One register stage per power of ten: each stage finds its digit by
// comparing against the nine multiples, subtracts, and collects the
// significant digits.
// ============================================================================
module sdaf_digit_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sdaf_pkg::t_work i_work,
    output logic            o_ready,
    output logic            o_valid,
    output sdaf_pkg::t_work o_work,
    input  logic            i_ready
);
    import sdaf_pkg::*;

    logic                r_v    [NUM_DIGITS];
    t_work               r_work [NUM_DIGITS];
    logic [NUM_DIGITS:0] w_rdy;

    // ready ripples back from the output end
    assign w_rdy[NUM_DIGITS] = i_ready;

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_stage
        localparam logic [63:0] PWR = pow10(HIGHEST_POWER - k);

        logic   w_v_in;
        t_work  w_in;
        t_work  n_work;
        logic   [8:0] w_ge;
        t_digit w_digit;
        logic   [63:0] w_sub;
        logic   w_started;

        if (k == 0) begin : g_first
            assign w_v_in = i_valid;
            assign w_in   = i_work;
        end else begin : g_next
            assign w_v_in = r_v[k-1];
            assign w_in   = r_work[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // digit of this power and remainder
        always_comb begin
            w_digit = '0;
            w_sub   = '0;
            for (int d = 1; d <= 9; d++) begin
                w_ge[d-1] = 64'(w_in.mag) >= (64'(d) * PWR);
                if (w_ge[d-1]) begin
                    w_digit = 4'(d);
                    w_sub   = 64'(d) * PWR;
                end
            end
            w_started = w_in.started || (w_digit != '0) || (k == NUM_DIGITS - 1);
            n_work = w_in;
            n_work.mag = w_in.mag - w_sub[MAG_W-1:0];
            n_work.started = w_started;
            if (w_started) begin
                for (int i = NUM_DIGITS - 1; i > 0; i--) begin
                    n_work.digs[i] = w_in.digs[i-1];
                end
                n_work.digs[0] = w_digit;
                n_work.cnt = CNT_W'(w_in.cnt + 1'b1);
            end
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_work[k] <= n_work;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NUM_DIGITS-1];
    assign o_work  = r_work[NUM_DIGITS-1];

endmodule

// File: hdl/sdaf_serializer.sv
// ============================================================================
// sdaf_serializer
// Holds one formatted number and hands out its characters one word at a
// time: the minus sign if any, then the significant digits.
// ============================================================================
module sdaf_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sdaf_pkg::t_work i_work,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_char_code,
    output logic            o_last_char,
    input  logic            i_ready
);
    import sdaf_pkg::*;

    logic                 r_busy;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    t_digits              r_digs;
    logic [CNT_W-1:0]     w_cnt_m1;
    logic                 w_take;
    logic                 w_load;

    // current character
    assign w_cnt_m1    = r_cnt - 1'b1;
    assign o_valid     = r_busy;
    assign o_last_char = !r_neg && (r_cnt == CNT_W'(1));
    assign o_char_code = r_neg ? CHAR_MINUS
                               : CHAR_ZERO + {4'b0, r_digs[w_cnt_m1[DIG_IDX_W-1:0]]};

    // next number loads as the last word of this one leaves
    assign w_take  = r_busy && i_ready;
    assign o_ready = !r_busy || (i_ready && o_last_char);
    assign w_load  = i_valid && o_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_neg  <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_neg  <= i_work.neg;
            r_cnt  <= i_work.cnt;
        end else if (w_take) begin
            if (o_last_char) begin
                r_busy <= 1'b0;
            end else if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_cnt <= w_cnt_m1;
            end
        end
    end

    // digit store
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digs <= i_work.digs;
        end
    end

endmodule

// File: hdl/signed_decimal_ascii_formatter.sv
// ============================================================================
// signed_decimal_ascii_formatter
// Turns a signed 32-bit number into its decimal ASCII text, one character
// per output word.
// ============================================================================
// A number enters on i_in and leaves on o_out as 1 to 11 characters: '-' for
// a negative value, then the significant digits, most significant first, with
// last_char set on the units digit (zero prints as "0"). The input can take a
// new number in every cycle while the pipeline is not stalled by the output;
// an entry stage and one stage per power of ten (eleven) sit before the
// output stage. The output sends one character per cycle while o_out.ready is
// high, so the character count of each number sets the sustained rate. No
// clearing after reset.
// ============================================================================
module signed_decimal_ascii_formatter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdaf_in_if.sink    i_in,
    sdaf_out_if.source o_out
);
    import sdaf_pkg::*;

    logic  w_front_valid;
    logic  w_front_ready;
    t_work w_front_work;
    logic  w_pipe_valid;
    logic  w_pipe_ready;
    t_work w_pipe_work;

    // sign and magnitude
    sdaf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_value (i_in.value),
        .o_ready (i_in.ready),
        .o_valid (w_front_valid),
        .o_work  (w_front_work),
        .i_ready (w_front_ready)
    );

    // digit extraction
    sdaf_digit_pipe u_digit_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_work  (w_front_work),
        .o_ready (w_front_ready),
        .o_valid (w_pipe_valid),
        .o_work  (w_pipe_work),
        .i_ready (w_pipe_ready)
    );

    // character output
    sdaf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_pipe_valid),
        .i_work      (w_pipe_work),
        .o_ready     (w_pipe_ready),
        .o_valid     (o_out.valid),
        .o_char_code (o_out.char_code),
        .o_last_char (o_out.last_char),
        .i_ready     (o_out.ready)
    );

endmodule

// File: hdl/sdaf_checker.sv
// ============================================================================
// sdaf_checker
// Port-level checks on the character output of the formatter, bound to the
// top level.
// ============================================================================
module sdaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char_code,
    input logic       i_out_last_char
);
    import sdaf_pkg::*;

    // a stalled word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_char_code) && $stable(i_out_last_char))
        else $error("output payload changed while stalled");

    // only minus sign and decimal digits appear
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char_code == CHAR_MINUS) ||
                        ((i_out_char_code >= CHAR_ZERO) && (i_out_char_code <= 8'h39)))
        else $error("illegal character code");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char_code == CHAR_MINUS) |-> !i_out_last_char)
        else $error("minus sign flagged as last character");

    // a minus sign is followed by a digit, not another sign
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_char_code == CHAR_MINUS)
        |=> i_out_valid && (i_out_char_code != CHAR_MINUS))
        else $error("minus sign not followed by a digit");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_char_code (o_out.char_code),
    .i_out_last_char (o_out.last_char)
);
